// ===== rtl/core/mcmf_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-channel mailbox FIFO package
// Shared types and fixed widths for the mailbox bank.
// ----------------------------------------------------------------------------
`default_nettype none

package mcmf_pkg;

  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned DATA_W      = 64;
  localparam int unsigned MBOX_W      = 8;
  localparam int unsigned S_TUSER_W   = 2;
  localparam int unsigned S_TDATA_W   = 72;
  localparam int unsigned M_TUSER_W   = 4;
  localparam int unsigned M_TDATA_W   = 64;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_BAD  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BADCH = 2'd3
  } status_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_READ = 1'b1
  } back_state_e;

  typedef struct packed {
    op_e                op;
    logic [MBOX_W-1:0]  mbox;
    logic [DATA_W-1:0]  data;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic               full;
    logic               empty;
    logic [DATA_W-1:0]  data;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/mcmf_front.sv =====
// ----------------------------------------------------------------------------
// Mailbox request front end
// Accepts request words, checks the channel and forms the mailbox index.
// ----------------------------------------------------------------------------
`default_nettype none

module mcmf_front
  import mcmf_pkg::*;
#(
  parameter int unsigned CHANNELS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_tvalid_i,
  output logic                      s_tready_o,
  input  wire logic [S_TUSER_W-1:0] s_tuser_i,
  input  wire logic [S_TDATA_W-1:0] s_tdata_i,
  output logic                      req_valid_o,
  input  wire logic                 req_ready_i,
  output req_t                      req_o
);

  logic         valid_q, valid_d;
  req_t         req_q;
  req_t         req_cls;
  logic         accept;
  logic [CHAN_W-1:0] chan;

  assign chan = s_tdata_i[CHAN_W-1:0];

  always_comb begin
    req_cls.data = s_tdata_i[CHAN_W +: DATA_W];
    req_cls.mbox = {chan[MBOX_W-2:0], s_tuser_i[1]};
    if (chan >= CHAN_W'(CHANNELS)) begin
      req_cls.op = OP_BAD;
    end else if (s_tuser_i[0]) begin
      req_cls.op = OP_POP;
    end else begin
      req_cls.op = OP_PUSH;
    end
  end

  assign s_tready_o  = !valid_q || req_ready_i;
  assign accept      = s_tvalid_i && s_tready_o;
  assign valid_d     = accept || (valid_q && !req_ready_i);
  assign req_valid_o = valid_q;
  assign req_o       = req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_cls;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mcmf_queue.sv =====
// ----------------------------------------------------------------------------
// Mailbox request queue
// Short FIFO of classified requests between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mcmf_queue
  import mcmf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire req_t push_req_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output req_t      pop_req_o
);

  req_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_req_o    = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mcmf_back.sv =====
// ----------------------------------------------------------------------------
// Mailbox execution back end
// Holds mailbox pointers, fill counts and the event store; runs push and pop.
// ----------------------------------------------------------------------------
`default_nettype none

module mcmf_back
  import mcmf_pkg::*;
#(
  parameter int unsigned CHANNELS    = 16,
  parameter int unsigned DEPTH       = 8,
  parameter int unsigned EVENT_WIDTH = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_ready_o,
  input  wire req_t req_i,
  output logic      m_tvalid_o,
  input  wire logic m_tready_i,
  output result_t   m_result_o
);

  localparam int unsigned MBOX_N   = 2 * CHANNELS;
  localparam int unsigned MBOX_AW  = $clog2(MBOX_N);
  localparam int unsigned SLOT_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned STORE_AW = MBOX_AW + SLOT_W;
  localparam int unsigned STORE_N  = MBOX_N << SLOT_W;

  back_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  result_t     out_q, out_d;

  logic [SLOT_W-1:0] rd_ptr_q [MBOX_N];
  logic [SLOT_W-1:0] wr_ptr_q [MBOX_N];
  logic [CNT_W-1:0]  cnt_q    [MBOX_N];
  logic [SLOT_W-1:0] rd_ptr_d, wr_ptr_d;
  logic [CNT_W-1:0]  cnt_d;
  logic [SLOT_W-1:0] cur_rd, cur_wr;
  logic [CNT_W-1:0]  cur_cnt;
  logic [MBOX_AW-1:0] mb;
  logic              mbox_we;

  logic [EVENT_WIDTH-1:0] store [STORE_N];
  logic [EVENT_WIDTH-1:0] rdata_q;
  logic                   store_we, store_re;

  function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] p);
    return (p == SLOT_W'(DEPTH - 1)) ? '0 : p + SLOT_W'(1);
  endfunction

  assign mb      = req_i.mbox[MBOX_AW-1:0];
  assign cur_rd  = rd_ptr_q[mb];
  assign cur_wr  = wr_ptr_q[mb];
  assign cur_cnt = cnt_q[mb];

  always_comb begin
    state_d     = state_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_tready_i;
    req_ready_o = 1'b0;
    mbox_we     = 1'b0;
    store_we    = 1'b0;
    store_re    = 1'b0;
    rd_ptr_d    = cur_rd;
    wr_ptr_d    = cur_wr;
    cnt_d       = cur_cnt;
    unique case (state_q)
      BK_IDLE: begin
        if (req_valid_i && (!out_valid_q || m_tready_i)) begin
          req_ready_o = 1'b1;
          out_d.data  = '0;
          case (req_i.op)
            OP_PUSH: begin
              if (cur_cnt == CNT_W'(DEPTH)) begin
                out_d.status = ST_FULL;
              end else begin
                out_d.status = ST_DONE;
                store_we     = 1'b1;
                mbox_we      = 1'b1;
                wr_ptr_d     = slot_next(cur_wr);
                cnt_d        = cur_cnt + CNT_W'(1);
              end
              out_d.full  = (cnt_d == CNT_W'(DEPTH));
              out_d.empty = (cnt_d == '0);
              out_valid_d = 1'b1;
            end
            OP_POP: begin
              if (cur_cnt == '0) begin
                out_d.status = ST_EMPTY;
                out_valid_d  = 1'b1;
              end else begin
                // word comes back from the store next cycle
                out_d.status = ST_DONE;
                store_re     = 1'b1;
                mbox_we      = 1'b1;
                rd_ptr_d     = slot_next(cur_rd);
                cnt_d        = cur_cnt - CNT_W'(1);
                state_d      = BK_READ;
              end
              out_d.full  = (cnt_d == CNT_W'(DEPTH));
              out_d.empty = (cnt_d == '0);
            end
            default: begin
              out_d.status = ST_BADCH;
              out_d.full   = 1'b0;
              out_d.empty  = 1'b1;
              out_valid_d  = 1'b1;
            end
          endcase
        end
      end
      BK_READ: begin
        out_d.data  = DATA_W'(rdata_q);
        out_valid_d = 1'b1;
        state_d     = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MBOX_N; i++) begin
        rd_ptr_q[i] <= '0;
        wr_ptr_q[i] <= '0;
        cnt_q[i]    <= '0;
      end
    end else if (mbox_we) begin
      rd_ptr_q[mb] <= rd_ptr_d;
      wr_ptr_q[mb] <= wr_ptr_d;
      cnt_q[mb]    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store[STORE_AW'({mb, cur_wr})] <= req_i.data[EVENT_WIDTH-1:0];
    end
    if (store_re) begin
      rdata_q <= store[STORE_AW'({mb, cur_rd})];
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_result_o = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/multi_channel_mailbox_fifo.sv =====
// ----------------------------------------------------------------------------
// Multi-channel mailbox FIFO
// Bank of 2*CHANNELS circular event mailboxes with push/pop requests.
// ----------------------------------------------------------------------------
// Each request word pushes or pops one event in the inbound or outbound
// mailbox of a channel and returns exactly one result word, in request order:
// status, popped event (zero unless popped), and the mailbox full/empty flags
// after the operation. Requests pass a registered front end and a two-word
// queue before the back end, whose result word is registered. The back end
// retires one push, pop of an empty mailbox or rejected request per cycle
// while the result output is not stalled; a pop that returns a word then
// passes BK_READ, taking no new request, for the registered store read.
`default_nettype none

module multi_channel_mailbox_fifo
  import mcmf_pkg::*;
#(
  parameter int unsigned CHANNELS    = 16,
  parameter int unsigned DEPTH       = 8,
  parameter int unsigned EVENT_WIDTH = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [S_TUSER_W-1:0] s_axis_tuser,  // req_type, direction
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // channel[7:0], event_data[71:8]
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [M_TUSER_W-1:0]      m_axis_tuser,  // op_status[1:0], is_full, is_empty
  output logic [M_TDATA_W-1:0]      m_axis_tdata   // event_out
);

  logic    fr_valid, fr_ready;
  req_t    fr_req;
  logic    q_valid, q_ready;
  req_t    q_req;
  result_t result;

  mcmf_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_tuser_i   (s_axis_tuser),
    .s_tdata_i   (s_axis_tdata),
    .req_valid_o (fr_valid),
    .req_ready_i (fr_ready),
    .req_o       (fr_req)
  );

  mcmf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_req_i   (fr_req),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_req_o    (q_req)
  );

  mcmf_back #(
    .CHANNELS    (CHANNELS),
    .DEPTH       (DEPTH),
    .EVENT_WIDTH (EVENT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (q_valid),
    .req_ready_o (q_ready),
    .req_i       (q_req),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_result_o  (result)
  );

  assign m_axis_tuser = {result.empty, result.full, result.status};
  assign m_axis_tdata = result.data;

endmodule

`default_nettype wire

// ===== sim/mailbox_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mailbox bank checker
// Watches the request and result streams of the mailbox FIFO bank, keeps its
// own copy of every mailbox (slots, pointers, fill levels), predicts the
// result word of each accepted request and compares the returned words in
// order, field by field.
// ----------------------------------------------------------------------------

module mailbox_checker
  import mcmf_pkg::*;
#(
  parameter int unsigned CHANNELS    = 16,
  parameter int unsigned DEPTH       = 8,
  parameter int unsigned EVENT_WIDTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [S_TUSER_W-1:0] s_axis_tuser,  // req_type, direction
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // channel[7:0], event_data[71:8]
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [M_TUSER_W-1:0] m_axis_tuser,  // op_status[1:0], is_full, is_empty
  input  logic [M_TDATA_W-1:0] m_axis_tdata,  // event_out
  output int                   mismatches,
  output int                   pending_words
);

  localparam int unsigned MBOXES = 2 * CHANNELS;
  localparam logic [DATA_W-1:0] EV_MASK = {DATA_W{1'b1}} >> (DATA_W - EVENT_WIDTH);
  localparam int unsigned PRINT_CAP = 40;

  typedef struct {
    status_e           status;
    logic              full;
    logic              empty;
    logic [DATA_W-1:0] ev_word;
  } mbox_result_t;

  logic [DATA_W-1:0] slot_words [MBOXES][DEPTH];
  int unsigned       rd_slot    [MBOXES];
  int unsigned       wr_slot    [MBOXES];
  int unsigned       fill_level [MBOXES];
  mbox_result_t      awaited_results [$];

  initial mismatches = 0;

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) begin
      $display("%0t mailbox_checker: %s", $realtime, what);
    end
    mismatches++;
  endtask

  function automatic mbox_result_t apply_request(input logic is_pop, input logic dir,
                                                 input logic [CHAN_W-1:0] chan,
                                                 input logic [DATA_W-1:0] ev);
    mbox_result_t r;
    int unsigned  mb;
    r.status  = ST_DONE;
    r.ev_word = '0;
    if (chan >= CHANNELS) begin
      r.status = ST_BADCH;
      r.full   = 1'b0;
      r.empty  = 1'b1;
      return r;
    end
    mb = 2 * chan + dir;
    if (!is_pop) begin
      if (fill_level[mb] >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        slot_words[mb][wr_slot[mb]] = ev & EV_MASK;
        wr_slot[mb] = (wr_slot[mb] + 1 >= DEPTH) ? 0 : wr_slot[mb] + 1;
        fill_level[mb]++;
      end
    end else begin
      if (fill_level[mb] == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.ev_word = slot_words[mb][rd_slot[mb]] & EV_MASK;
        rd_slot[mb] = (rd_slot[mb] + 1 >= DEPTH) ? 0 : rd_slot[mb] + 1;
        fill_level[mb]--;
      end
    end
    r.full  = (fill_level[mb] >= DEPTH);
    r.empty = (fill_level[mb] == 0);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    mbox_result_t want;
    if (!rst_ni) begin
      awaited_results.delete();
      for (int m = 0; m < MBOXES; m++) begin
        rd_slot[m]    = 0;
        wr_slot[m]    = 0;
        fill_level[m] = 0;
      end
      pending_words <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result word with no request outstanding");
        end else begin
          want = awaited_results.pop_front();
          if (m_axis_tuser[1:0] !== want.status) begin
            report_mismatch($sformatf("op_status %0d, expected %0d",
                                      m_axis_tuser[1:0], want.status));
          end
          if (m_axis_tuser[2] !== want.full) begin
            report_mismatch($sformatf("is_full %b, expected %b", m_axis_tuser[2], want.full));
          end
          if (m_axis_tuser[3] !== want.empty) begin
            report_mismatch($sformatf("is_empty %b, expected %b",
                                      m_axis_tuser[3], want.empty));
          end
          if (m_axis_tdata !== want.ev_word) begin
            report_mismatch($sformatf("event_out %h, expected %h", m_axis_tdata, want.ev_word));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_results.push_back(apply_request(s_axis_tuser[0], s_axis_tuser[1],
                                                s_axis_tdata[CHAN_W-1:0],
                                                s_axis_tdata[CHAN_W +: DATA_W]));
      end
      pending_words <= awaited_results.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mailbox FIFO bank testbench
// Drives push/pop request words into the mailbox bank with random gaps and
// result back-pressure: a directed pass over full, empty and bad-channel
// cases, then random traffic biased toward a few mailboxes so they fill and
// drain. The checker predicts and compares every result word.
// ----------------------------------------------------------------------------

module testbench;
  import mcmf_pkg::*;

  localparam int unsigned CHANNELS     = 16;
  localparam int unsigned DEPTH        = 8;
  localparam int unsigned EVENT_WIDTH  = 64;
  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned QUIET_ITEMS  = 150;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;
  localparam logic DIR_IN   = 1'b0;
  localparam logic DIR_OUT  = 1'b1;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TUSER_W-1:0] s_axis_tuser;  // req_type, direction
  logic [S_TDATA_W-1:0] s_axis_tdata;  // channel[7:0], event_data[71:8]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TUSER_W-1:0] m_axis_tuser;  // op_status[1:0], is_full, is_empty
  logic [M_TDATA_W-1:0] m_axis_tdata;  // event_out
  logic                 quiet;
  int                   mismatches;
  int                   pending_words;
  int unsigned          cycle_count = 0;

  always #5 clk_i = ~clk_i;

  multi_channel_mailbox_fifo #(
    .CHANNELS   (CHANNELS),
    .DEPTH      (DEPTH),
    .EVENT_WIDTH(EVENT_WIDTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tdata (m_axis_tdata)
  );

  mailbox_checker #(
    .CHANNELS   (CHANNELS),
    .DEPTH      (DEPTH),
    .EVENT_WIDTH(EVENT_WIDTH)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tdata (m_axis_tdata),
    .mismatches   (mismatches),
    .pending_words(pending_words)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // result back-pressure
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_request(input logic is_pop, input logic dir,
                              input logic [CHAN_W-1:0] chan, input logic [DATA_W-1:0] ev);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {dir, is_pop};
    s_axis_tdata  <= {ev, chan};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [DATA_W-1:0] random_word();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick < 3) return '1;
    return {$urandom, $urandom};
  endfunction

  initial begin : stimulus
    int unsigned push_pct;
    int unsigned pick;
    logic [CHAN_W-1:0] chan;
    rst_ni        <= 1'b0;
    quiet         <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= '0;
    s_axis_tdata  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // data extremes, then pop past empty
    send_request(REQ_PUSH, DIR_IN, 8'd0, '1);
    send_request(REQ_PUSH, DIR_IN, 8'd0, '0);
    send_request(REQ_POP, DIR_IN, 8'd0, random_word());
    send_request(REQ_POP, DIR_IN, 8'd0, random_word());
    send_request(REQ_POP, DIR_IN, 8'd0, '1);
    // fill the top outbound mailbox, one push dropped when full
    for (int i = 0; i <= DEPTH; i++) begin
      send_request(REQ_PUSH, DIR_OUT, CHAN_W'(CHANNELS - 1), random_word());
    end
    send_request(REQ_POP, DIR_OUT, CHAN_W'(CHANNELS - 1), '0);
    // channels out of range
    send_request(REQ_PUSH, DIR_IN, CHAN_W'(CHANNELS), '1);
    send_request(REQ_POP, DIR_OUT, 8'hff, random_word());
    send_request(REQ_PUSH, DIR_OUT, 8'h80, random_word());

    push_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        pick = $urandom_range(0, 2);
        push_pct = (pick == 0) ? 25 : (pick == 1) ? 50 : 80;
      end
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet <= 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 60) chan = CHAN_W'($urandom_range(0, 3));
      else if (pick < 85) chan = CHAN_W'($urandom_range(0, CHANNELS - 1));
      else chan = CHAN_W'($urandom_range(CHANNELS, 255));
      send_request(($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP,
                   1'($urandom_range(0, 1)), chan, random_word());
    end
    s_axis_tvalid <= 1'b0;

    repeat (2) @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_words == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
